[design/urrfc_pkg.sv]
// Package for the serial receive ring with XOFF and RTS flow control.
// Holds the command codes, register indexes and reset values.
// Depends on nothing.
`timescale 1ns / 1ps

package urrfc_pkg;

  localparam int DEFAULT_RING_DEPTH = 256;

  localparam int CMD_W = 2;
  localparam logic [CMD_W-1:0] CMD_RECEIVE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_POP     = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR   = 2'd2;

  localparam int REG_INDEX_W = 2;
  localparam int REG_DATA_W  = 8;
  localparam logic [REG_INDEX_W-1:0] REG_XOFF_ENABLE    = 2'd0;
  localparam logic [REG_INDEX_W-1:0] REG_RTS_ENABLE     = 2'd1;
  localparam logic [REG_INDEX_W-1:0] REG_STOP_THRESHOLD = 2'd2;

  localparam logic [7:0] STOP_THRESHOLD_RESET = 8'd192;

endpackage

[design/uart_rx_ring_flow_control.sv]
// Top level of the serial receive ring: a byte ring in one memory with XOFF or,
// with XOFF off, RTS stop requests raised once the fill level passes a threshold.
// Depends on urrfc_pkg.
//
//   channel   direction  handshake             payload
//   command   in         start, busy           command, rx_byte
//   result    out        done (one cycle)      read_byte, read_valid, stored, dropped,
//                                              send_xoff, raise_rts, fill_level,
//                                              xoff_sent, rts_held
//   config    in         cfg_write             cfg_index, cfg_data
//
// One beat is taken every cycle; busy stays low. The result of a beat is on
// the result ports in the cycle after it is taken, because the popped
// byte comes from the registered read port of the ring memory.
// Reset clears the indexes, the fill count, the flags and the registers; the
// ring memory itself is not cleared. The receiver cannot stall results.
`timescale 1ns / 1ps

module uart_rx_ring_flow_control
  import urrfc_pkg::*;
#(
  parameter int RING_DEPTH = DEFAULT_RING_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  logic [CMD_W-1:0]       command,
  input  logic [7:0]             rx_byte,
  output logic                   done,
  output logic [7:0]             read_byte,
  output logic                   read_valid,
  output logic                   stored,
  output logic                   dropped,
  output logic                   send_xoff,
  output logic                   raise_rts,
  output logic [7:0]             fill_level,
  output logic                   xoff_sent,
  output logic                   rts_held,
  input  logic                   cfg_write,
  input  logic [REG_INDEX_W-1:0] cfg_index,
  input  logic [REG_DATA_W-1:0]  cfg_data
);

  localparam int IDX_W = $clog2(RING_DEPTH);
  localparam int LVL_W = (IDX_W > 8) ? IDX_W : 8;
  localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(RING_DEPTH - 1);

  logic [7:0]       ring_mem [RING_DEPTH];
  logic [7:0]       rd_data;

  logic [IDX_W-1:0] write_index, write_index_next;
  logic [IDX_W-1:0] read_index, read_index_next;
  logic [IDX_W-1:0] count, count_next;
  logic             xoff_latched, xoff_latched_next;
  logic             rts_latched, rts_latched_next;
  logic             xoff_enable, rts_enable;
  logic [7:0]       stop_threshold;

  logic             accept;
  logic             ring_full, ring_empty;
  logic             mem_we, mem_re;
  logic [LVL_W-1:0] level_after_store, level_wide;
  logic             over_threshold;
  logic             stored_next, dropped_next, read_valid_next;
  logic             send_xoff_next, raise_rts_next;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign ring_full  = (count == LAST_SLOT);
  assign ring_empty = (count == '0);

  assign level_after_store = LVL_W'(count) + LVL_W'(1);
  assign over_threshold    = level_after_store > LVL_W'(stop_threshold);

  always_comb begin
    write_index_next  = write_index;
    read_index_next   = read_index;
    count_next        = count;
    xoff_latched_next = xoff_latched;
    rts_latched_next  = rts_latched;
    mem_we            = 1'b0;
    mem_re            = 1'b0;
    stored_next       = 1'b0;
    dropped_next      = 1'b0;
    read_valid_next   = 1'b0;
    send_xoff_next    = 1'b0;
    raise_rts_next    = 1'b0;
    unique case (command)
      CMD_RECEIVE: begin
        if (ring_full) begin
          dropped_next = 1'b1;
        end else begin
          mem_we           = 1'b1;
          stored_next      = 1'b1;
          write_index_next = (write_index == LAST_SLOT) ? '0 : write_index + IDX_W'(1);
          count_next       = count + IDX_W'(1);
          if (xoff_enable) begin
            if (over_threshold && !xoff_latched) begin
              xoff_latched_next = 1'b1;
              send_xoff_next    = 1'b1;
            end
          end else if (rts_enable) begin
            if (over_threshold && !rts_latched) begin
              rts_latched_next = 1'b1;
              raise_rts_next   = 1'b1;
            end
          end
        end
      end
      CMD_POP: begin
        if (!ring_empty) begin
          mem_re          = 1'b1;
          read_valid_next = 1'b1;
          read_index_next = (read_index == LAST_SLOT) ? '0 : read_index + IDX_W'(1);
          count_next      = count - IDX_W'(1);
        end
      end
      CMD_CLEAR: begin
        xoff_latched_next = 1'b0;
        rts_latched_next  = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept && mem_we) begin
      ring_mem[write_index] <= rx_byte;
    end
    if (accept && mem_re) begin
      rd_data <= ring_mem[read_index];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_index  <= '0;
      read_index   <= '0;
      count        <= '0;
      xoff_latched <= 1'b0;
      rts_latched  <= 1'b0;
      done         <= 1'b0;
      read_valid   <= 1'b0;
      stored       <= 1'b0;
      dropped      <= 1'b0;
      send_xoff    <= 1'b0;
      raise_rts    <= 1'b0;
    end else begin
      done <= accept;
      if (accept) begin
        write_index  <= write_index_next;
        read_index   <= read_index_next;
        count        <= count_next;
        xoff_latched <= xoff_latched_next;
        rts_latched  <= rts_latched_next;
        read_valid   <= read_valid_next;
        stored       <= stored_next;
        dropped      <= dropped_next;
        send_xoff    <= send_xoff_next;
        raise_rts    <= raise_rts_next;
      end else begin
        read_valid <= 1'b0;
        stored     <= 1'b0;
        dropped    <= 1'b0;
        send_xoff  <= 1'b0;
        raise_rts  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      xoff_enable    <= 1'b0;
      rts_enable     <= 1'b0;
      stop_threshold <= STOP_THRESHOLD_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_XOFF_ENABLE:    xoff_enable    <= cfg_data[0];
        REG_RTS_ENABLE:     rts_enable     <= cfg_data[0];
        REG_STOP_THRESHOLD: stop_threshold <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign level_wide = LVL_W'(count);
  assign fill_level = (level_wide > LVL_W'(8'hFF)) ? 8'hFF : level_wide[7:0];
  assign read_byte  = read_valid ? rd_data : 8'h00;
  assign xoff_sent  = xoff_latched;
  assign rts_held   = rts_latched;

  // A result strobe only ever comes in the cycle after a taken beat.
  assert property (@(posedge clk) disable iff (rst) done |-> $past(accept))
    else $error("result strobe without a taken beat");

  // Result flags appear only alongside the strobe.
  assert property (@(posedge clk) disable iff (rst)
    (stored || dropped || read_valid || send_xoff || raise_rts) |-> done)
    else $error("result flag outside a result beat");

  // The fill count never reaches the ring depth, since one slot stays empty.
  assert property (@(posedge clk) disable iff (rst)
    (LVL_W'(count) <= LVL_W'(LAST_SLOT)))
    else $error("fill count beyond ring capacity");

  // A stop request is always mirrored by its held flag.
  assert property (@(posedge clk) disable iff (rst)
    (send_xoff |-> xoff_sent) and (raise_rts |-> rts_held))
    else $error("stop request without its flag set");

endmodule
